// File: hdl/scpq_pkg.sv
// ----------------------------------------------------------------------------
// scpq_pkg
// Shared constants and codes for the sphere closest point query block.
// ----------------------------------------------------------------------------
package scpq_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int RADIUS_W        = 31;
  localparam int TOL_W           = 16;
  localparam int REG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CLS_W           = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_RIM_TOL  = 3'd4
  } reg_idx_t;

  // how the back end forms the closest point
  typedef enum logic [CLS_W-1:0] {
    CLS_KEEP   = 2'd0,
    CLS_CENTRE = 2'd1,
    CLS_SCALE  = 2'd2
  } cls_t;

endpackage

// File: hdl/scpq_queue.sv
// ----------------------------------------------------------------------------
// scpq_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module scpq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;

  assign full     = (count_r == CNTW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/scpq_front.sv
// ----------------------------------------------------------------------------
// scpq_front
// Takes query points, forms offset, squared length and its integer square
// root, and classifies each point for the back end.
// ----------------------------------------------------------------------------
module scpq_front #(
  parameter int CW = scpq_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [CW-1:0]            in_point_x,
  input  logic signed [CW-1:0]            in_point_y,
  input  logic signed [CW-1:0]            in_point_z,
  input  logic                            in_rim_mode,
  input  logic signed [CW-1:0]            center_x,
  input  logic signed [CW-1:0]            center_y,
  input  logic signed [CW-1:0]            center_z,
  input  logic [scpq_pkg::RADIUS_W-1:0]   radius,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [4*(CW+1)+1+scpq_pkg::CLS_W-1:0] q_data
);

  import scpq_pkg::*;

  localparam int DW   = CW + 1;
  localparam int LW   = CW + 1;
  localparam int SW   = 2 * LW;
  localparam int CMPW = LW + RADIUS_W;

  logic front_en;

  logic                 s0_v_r;
  logic signed [DW-1:0] s0_d_r [3];
  logic                 s0_rim_r;

  logic                 s1_v_r;
  logic [SW-1:0]        s1_sq_r [3];
  logic [3*DW-1:0]      s1_d_r;
  logic                 s1_rim_r;

  logic                 sq_v_r    [LW+1];
  logic [SW-1:0]        sq_s_r    [LW+1];
  logic [LW+1:0]        sq_rem_r  [LW+1];
  logic [LW-1:0]        sq_root_r [LW+1];
  logic [3*DW-1:0]      sq_d_r    [LW+1];
  logic                 sq_rim_r  [LW+1];

  logic signed [CW-1:0] pnt [3];
  logic signed [CW-1:0] cen [3];
  logic [DW-1:0]        absd [3];
  logic [LW-1:0]        len;
  cls_t                 cls;

  assign pnt[0] = in_point_x;
  assign pnt[1] = in_point_y;
  assign pnt[2] = in_point_z;
  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  // the whole front moves together, held only when the queue cannot take the head
  assign front_en = !(sq_v_r[LW] && q_full);
  assign in_stall = !front_en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absd[i] = s0_d_r[i][DW-1] ? DW'(~s0_d_r[i] + 1'b1) : DW'(s0_d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
    end else if (front_en) begin
      s0_v_r    <= in_valid;
      s1_v_r    <= s0_v_r;
      sq_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      for (int i = 0; i < 3; i++) begin
        s0_d_r[i] <= DW'(pnt[i]) - DW'(cen[i]);
        s1_sq_r[i] <= SW'(absd[i] * absd[i]);
      end
      s0_rim_r <= in_rim_mode;
      s1_d_r   <= {s0_d_r[2], s0_d_r[1], s0_d_r[0]};
      s1_rim_r <= s0_rim_r;

      sq_s_r[0]    <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_d_r[0]    <= s1_d_r;
      sq_rim_r[0]  <= s1_rim_r;
    end
  end

  // one result bit of the square root per stage
  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    logic [LW+1:0] rem_sh;
    logic [LW+1:0] trial;
    logic          ge;

    assign rem_sh = {sq_rem_r[k][LW-1:0], sq_s_r[k][SW-1-2*k -: 2]};
    assign trial  = {sq_root_r[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (front_en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (front_en) begin
        sq_s_r[k+1]    <= sq_s_r[k];
        sq_rem_r[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][LW-2:0], ge};
        sq_d_r[k+1]    <= sq_d_r[k];
        sq_rim_r[k+1]  <= sq_rim_r[k];
      end
    end
  end

  assign len = sq_root_r[LW];

  always_comb begin
    if (CMPW'(len) < CMPW'(radius)) begin
      cls = CLS_KEEP;
    end else if (len == '0) begin
      cls = CLS_CENTRE;
    end else begin
      cls = CLS_SCALE;
    end
  end

  assign q_push = sq_v_r[LW] && !q_full;
  assign q_data = {cls, sq_rim_r[LW], len, sq_d_r[LW]};

endmodule

// File: hdl/scpq_back.sv
// ----------------------------------------------------------------------------
// scpq_back
// Keeps, zeroes or scales the offset (by radius over length, through a pipelined
// divider), adds the centre back, saturates and forms distance and inside flag.
// ----------------------------------------------------------------------------
module scpq_back #(
  parameter int CW = scpq_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  logic [4*(CW+1)+1+scpq_pkg::CLS_W-1:0] q_data,
  input  logic signed [CW-1:0]            center_x,
  input  logic signed [CW-1:0]            center_y,
  input  logic signed [CW-1:0]            center_z,
  input  logic [scpq_pkg::RADIUS_W-1:0]   radius,
  input  logic [scpq_pkg::TOL_W-1:0]      rim_tolerance,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [CW-1:0]            out_closest_x,
  output logic signed [CW-1:0]            out_closest_y,
  output logic signed [CW-1:0]            out_closest_z,
  output logic signed [CW-1:0]            out_signed_distance,
  output logic                            out_is_inside
);

  import scpq_pkg::*;

  localparam int DW  = CW + 1;
  localparam int LW  = CW + 1;
  localparam int PW  = DW + RADIUS_W;
  localparam int NW  = PW + 1;
  localparam int QW  = NW - LW;
  localparam int OW  = ((DW > QW) ? DW : QW) + 1;
  localparam int DSW = ((LW > RADIUS_W) ? LW : RADIUS_W) + 2;

  logic b_en;

  logic signed [DW-1:0] qd_d [3];
  logic [LW-1:0]        qd_len;
  logic                 qd_rim;
  cls_t                 qd_cls;
  logic [DW-1:0]        qd_abs [3];

  logic                 b1_v_r;
  logic [PW-1:0]        b1_prod_r [3];
  logic [LW-1:0]        b1_len_r;
  logic [3*DW-1:0]      b1_d_r;
  logic                 b1_rim_r;
  cls_t                 b1_cls_r;

  logic                 dv_v_r   [QW+1];
  logic [LW-1:0]        dv_rem_r [QW+1][3];
  logic [NW-1:0]        dv_num_r [QW+1][3];
  logic [QW-1:0]        dv_q_r   [QW+1][3];
  logic [LW-1:0]        dv_len_r [QW+1];
  logic [3*DW-1:0]      dv_d_r   [QW+1];
  logic                 dv_rim_r [QW+1];
  cls_t                 dv_cls_r [QW+1];

  logic                 out_valid_r;
  logic signed [CW-1:0] out_closest_r [3];
  logic signed [CW-1:0] out_dist_r;
  logic                 out_inside_r;

  logic signed [CW-1:0] cen [3];
  logic signed [CW-1:0] fin_c [3];
  logic signed [DSW-1:0] dist_raw;
  logic signed [DSW-1:0] bound;
  logic signed [CW-1:0] dist_sat;

  localparam logic signed [OW:0] VMAX = {{(OW-CW+1){1'b0}}, 1'b0, {(CW-1){1'b1}}};
  localparam logic signed [OW:0] VMIN = {{(OW-CW+2){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [DSW-1:0] DMAX = {{(DSW-CW){1'b0}}, 1'b0, {(CW-1){1'b1}}};
  localparam logic signed [DSW-1:0] DMIN = {{(DSW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  assign b_en  = !out_valid_r || !out_stall;
  assign q_pop = b_en && !q_empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qd_d[i]   = q_data[i*DW +: DW];
      qd_abs[i] = qd_d[i][DW-1] ? DW'(~qd_d[i] + 1'b1) : DW'(qd_d[i]);
    end
    qd_len = q_data[3*DW +: LW];
    qd_rim = q_data[3*DW+LW];
    qd_cls = cls_t'(q_data[3*DW+LW+1 +: CLS_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r    <= 1'b0;
      dv_v_r[0] <= 1'b0;
    end else if (b_en) begin
      b1_v_r    <= q_pop;
      dv_v_r[0] <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      for (int i = 0; i < 3; i++) begin
        b1_prod_r[i]   <= PW'(qd_abs[i] * radius);
        // rounding term: half the divisor
        dv_num_r[0][i] <= NW'(b1_prod_r[i]) + NW'(b1_len_r >> 1);
        dv_rem_r[0][i] <= '0;
        dv_q_r[0][i]   <= '0;
      end
      b1_len_r <= qd_len;
      b1_d_r   <= q_data[3*DW-1:0];
      b1_rim_r <= qd_rim;
      b1_cls_r <= qd_cls;

      dv_len_r[0] <= b1_len_r;
      dv_d_r[0]   <= b1_d_r;
      dv_rim_r[0] <= b1_rim_r;
      dv_cls_r[0] <= b1_cls_r;
    end
  end

  // restoring division, one quotient bit per stage; the top bits of the
  // numerator seed the remainder since the quotient fits in QW bits
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [LW:0]   t    [3];
    logic          ge   [3];
    logic [LW-1:0] nrem [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          t[i] = {dv_num_r[j][i][NW-1 -: LW], dv_num_r[j][i][QW-1-j]};
        end else begin
          t[i] = {dv_rem_r[j][i], dv_num_r[j][i][QW-1-j]};
        end
        ge[i]   = (t[i] >= {1'b0, dv_len_r[j]});
        nrem[i] = ge[i] ? LW'(t[i] - {1'b0, dv_len_r[j]}) : t[i][LW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (b_en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (b_en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j+1][i] <= nrem[i];
          dv_num_r[j+1][i] <= dv_num_r[j][i];
          dv_q_r[j+1][i]   <= {dv_q_r[j][i][QW-2:0], ge[i]};
        end
        dv_len_r[j+1] <= dv_len_r[j];
        dv_d_r[j+1]   <= dv_d_r[j];
        dv_rim_r[j+1] <= dv_rim_r[j];
        dv_cls_r[j+1] <= dv_cls_r[j];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_fin
    logic signed [DW-1:0] d;
    logic signed [OW-1:0] qs;
    logic signed [OW-1:0] off;
    logic signed [OW:0]   v;

    assign d  = dv_d_r[QW][i*DW +: DW];
    assign qs = $signed(OW'({1'b0, dv_q_r[QW][i]}));

    always_comb begin
      case (dv_cls_r[QW])
        CLS_KEEP:   off = OW'(d);
        CLS_CENTRE: off = '0;
        CLS_SCALE:  off = d[DW-1] ? -qs : qs;
        default:    off = '0;
      endcase
      v = (OW+1)'(cen[i]) + (OW+1)'(off);
      if (v > VMAX) begin
        fin_c[i] = VMAX[CW-1:0];
      end else if (v < VMIN) begin
        fin_c[i] = VMIN[CW-1:0];
      end else begin
        fin_c[i] = v[CW-1:0];
      end
    end
  end

  always_comb begin
    dist_raw = $signed(DSW'(dv_len_r[QW])) - $signed(DSW'(radius));
    bound    = dv_rim_r[QW] ? $signed(DSW'(rim_tolerance)) : '0;
    if (dist_raw > DMAX) begin
      dist_sat = DMAX[CW-1:0];
    end else if (dist_raw < DMIN) begin
      dist_sat = DMIN[CW-1:0];
    end else begin
      dist_sat = dist_raw[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_en) begin
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && dv_v_r[QW]) begin
      for (int i = 0; i < 3; i++) begin
        out_closest_r[i] <= fin_c[i];
      end
      out_dist_r   <= dist_sat;
      out_inside_r <= (dist_raw < bound);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_closest_x       = out_closest_r[0];
  assign out_closest_y       = out_closest_r[1];
  assign out_closest_z       = out_closest_r[2];
  assign out_signed_distance = out_dist_r;
  assign out_is_inside       = out_inside_r;

endmodule

// File: hdl/sphere_closest_point_query_top.sv
// ----------------------------------------------------------------------------
// sphere_closest_point_query_top
// Closest point on a configured sphere, signed distance and inside test.
// Pipeline: the bit-per-stage square root in the front end and the 32-stage
// divider in the back end.
// Throughput: one point per cycle, each unit fully pipelined, while neither out_stall nor a full queue holds it.
// Reset: clears pipeline and queue; centre and radius to 0, tolerance to 1.
// ----------------------------------------------------------------------------
module sphere_closest_point_query_top #(
  parameter int COORD_WIDTH = scpq_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  logic signed [COORD_WIDTH-1:0]        in_point_z,
  input  logic                                 in_rim_mode,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [COORD_WIDTH-1:0]        out_closest_x,
  output logic signed [COORD_WIDTH-1:0]        out_closest_y,
  output logic signed [COORD_WIDTH-1:0]        out_closest_z,
  output logic signed [COORD_WIDTH-1:0]        out_signed_distance,
  output logic                                 out_is_inside,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [scpq_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [((COORD_WIDTH > scpq_pkg::RADIUS_W) ? COORD_WIDTH
                 : scpq_pkg::RADIUS_W)-1:0]    cfg_data
);

  import scpq_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int QDW = 4 * (CW + 1) + 1 + CLS_W;

  logic signed [CW-1:0]   center_x_r;
  logic signed [CW-1:0]   center_y_r;
  logic signed [CW-1:0]   center_z_r;
  logic [RADIUS_W-1:0]    radius_r;
  logic [TOL_W-1:0]       rim_tol_r;

  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  logic [QDW-1:0]         q_wdata;
  logic [QDW-1:0]         q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= '0;
      rim_tol_r  <= TOL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_X: center_x_r <= cfg_data[CW-1:0];
        REG_CENTER_Y: center_y_r <= cfg_data[CW-1:0];
        REG_CENTER_Z: center_z_r <= cfg_data[CW-1:0];
        REG_RADIUS:   radius_r   <= cfg_data[RADIUS_W-1:0];
        REG_RIM_TOL:  rim_tol_r  <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scpq_front #(.CW(CW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_point_z  (in_point_z),
    .in_rim_mode (in_rim_mode),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .center_z    (center_z_r),
    .radius      (radius_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  scpq_queue #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  scpq_back #(.CW(CW)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_data              (q_rdata),
    .center_x            (center_x_r),
    .center_y            (center_y_r),
    .center_z            (center_z_r),
    .radius              (radius_r),
    .rim_tolerance       (rim_tol_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_closest_x       (out_closest_x),
    .out_closest_y       (out_closest_y),
    .out_closest_z       (out_closest_z),
    .out_signed_distance (out_signed_distance),
    .out_is_inside       (out_is_inside)
  );

endmodule
